// File: hdl/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// shared types and constants of the enhanced second-chance page replacer
// ----------------------------------------------------------------------------
package esc_pkg;

  localparam int FRAMES_DEF    = 16;
  localparam int PAGE_BITS_DEF = 20;

  localparam int              CFG_W     = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  localparam logic OP_ACCESS  = 1'b0;
  localparam logic OP_REFRESH = 1'b1;

  // frame class is {referenced, modified}, class none sorts above all
  localparam logic [2:0] CLASS_NONE = 3'd4;

  typedef struct packed {
    logic victim_dirty;
    logic victim_valid;
    logic fault;
    logic hit;
  } esc_flags_t;

endpackage

// File: hdl/esc_engine.sv
// ----------------------------------------------------------------------------
// esc_engine
// frame store and scan sequencer: one compare unit walks the frames for the
// hit search and victim class; a miss then shifts the list one slot a cycle
// ----------------------------------------------------------------------------
module esc_engine #(
  parameter int FRAMES    = 16,
  parameter int PAGE_BITS = 20
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic                    op,
  input  logic [PAGE_BITS-1:0]    page,
  input  logic                    wr,
  input  logic [esc_pkg::CFG_W-1:0] cfg_lim,
  input  logic                    res_take,
  output logic                    ready,
  output logic                    res_valid,
  output esc_pkg::esc_flags_t     res_flags,
  output logic [PAGE_BITS-1:0]    res_page
);
  import esc_pkg::*;

  localparam int IDX_W = $clog2(FRAMES);
  localparam int CNT_W = $clog2(FRAMES + 1);
  localparam int LW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_SHIFT = 5'b00100,
    S_FRONT = 5'b01000,
    S_DONE  = 5'b10000
  } esc_state_t;

  esc_state_t           state_r, state_nxt;
  logic [PAGE_BITS-1:0] page_r, page_nxt;
  logic                 wr_r, wr_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic                 cmp_v_r, cmp_v_nxt;
  logic [IDX_W-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic [2:0]           best_r, best_nxt;
  logic [IDX_W-1:0]     slot_r, slot_nxt;
  logic [PAGE_BITS-1:0] vpage_r, vpage_nxt;
  logic                 vdirty_r, vdirty_nxt;
  esc_flags_t           flags_r, flags_nxt;
  logic [CNT_W-1:0]     filled_r, filled_nxt;
  logic [FRAMES-1:0]    ref_r, ref_nxt;
  logic [FRAMES-1:0]    mod_r, mod_nxt;
  logic [IDX_W-1:0]     sh_idx_r, sh_idx_nxt;
  logic                 wp_v_r, wp_v_nxt;
  logic [IDX_W-1:0]     wp_idx_r, wp_idx_nxt;

  logic [PAGE_BITS-1:0] mem [FRAMES];
  logic [PAGE_BITS-1:0] rd_data_r;
  logic [IDX_W-1:0]     mem_ra;
  logic [IDX_W-1:0]     mem_wa;
  logic [PAGE_BITS-1:0] mem_wd;
  logic                 mem_we;

  logic [IDX_W-1:0]     sh_prev;
  logic [2:0]           cls;
  logic [LW-1:0]        cfg_ext;
  logic [LW-1:0]        lim;

  assign sh_prev = sh_idx_r - IDX_W'(1);
  assign cls     = {1'b0, ref_r[cmp_idx_r], mod_r[cmp_idx_r]};
  assign cfg_ext = LW'(cfg_lim);
  assign lim     = (cfg_ext == '0) ? LW'(1) :
                   ((cfg_ext > LW'(FRAMES)) ? LW'(FRAMES) : cfg_ext);

  assign mem_ra = (state_r == S_SCAN) ? idx_r[IDX_W-1:0] : sh_prev;
  assign mem_we = ((state_r == S_SHIFT) && wp_v_r) || (state_r == S_FRONT);
  assign mem_wa = (state_r == S_FRONT) ? '0 : wp_idx_r;
  assign mem_wd = (state_r == S_FRONT) ? page_r : rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

  always_comb begin
    state_nxt   = state_r;
    page_nxt    = page_r;
    wr_nxt      = wr_r;
    idx_nxt     = idx_r;
    cmp_v_nxt   = cmp_v_r;
    cmp_idx_nxt = cmp_idx_r;
    best_nxt    = best_r;
    slot_nxt    = slot_r;
    vpage_nxt   = vpage_r;
    vdirty_nxt  = vdirty_r;
    flags_nxt   = flags_r;
    filled_nxt  = filled_r;
    ref_nxt     = ref_r;
    mod_nxt     = mod_r;
    sh_idx_nxt  = sh_idx_r;
    wp_v_nxt    = wp_v_r;
    wp_idx_nxt  = wp_idx_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          page_nxt   = page;
          wr_nxt     = wr;
          idx_nxt    = '0;
          cmp_v_nxt  = 1'b0;
          best_nxt   = CLASS_NONE;
          slot_nxt   = '0;
          vpage_nxt  = '0;
          vdirty_nxt = 1'b0;
          flags_nxt  = '0;
          if (op == OP_REFRESH) begin
            ref_nxt   = '0;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmp_v_nxt = 1'b0;
        if (idx_r < filled_r) begin
          cmp_v_nxt   = 1'b1;
          cmp_idx_nxt = idx_r[IDX_W-1:0];
          idx_nxt     = idx_r + CNT_W'(1);
        end
        if (cmp_v_r) begin
          if (rd_data_r == page_r) begin
            ref_nxt[cmp_idx_r] = 1'b1;
            if (wr_r) begin
              mod_nxt[cmp_idx_r] = 1'b1;
            end
            flags_nxt.hit = 1'b1;
            vpage_nxt     = '0;
            cmp_v_nxt     = 1'b0;
            state_nxt     = S_DONE;
          end else if (cls < best_r) begin
            best_nxt   = cls;
            slot_nxt   = cmp_idx_r;
            vpage_nxt  = rd_data_r;
            vdirty_nxt = mod_r[cmp_idx_r];
          end
        end else if (idx_r >= filled_r) begin
          flags_nxt.fault = 1'b1;
          wp_v_nxt        = 1'b0;
          if (LW'(filled_r) < lim) begin
            sh_idx_nxt = filled_r[IDX_W-1:0];
            filled_nxt = filled_r + CNT_W'(1);
            vpage_nxt  = '0;
          end else begin
            flags_nxt.victim_valid = 1'b1;
            flags_nxt.victim_dirty = vdirty_r;
            sh_idx_nxt             = slot_r;
          end
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        wp_v_nxt = 1'b0;
        if (sh_idx_r != '0) begin
          ref_nxt[sh_idx_r] = ref_r[sh_prev];
          mod_nxt[sh_idx_r] = mod_r[sh_prev];
          wp_v_nxt          = 1'b1;
          wp_idx_nxt        = sh_idx_r;
          sh_idx_nxt        = sh_prev;
        end else if (!wp_v_r) begin
          state_nxt = S_FRONT;
        end
      end
      S_FRONT: begin
        ref_nxt[0] = 1'b1;
        mod_nxt[0] = wr_r;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cmp_v_r  <= 1'b0;
      wp_v_r   <= 1'b0;
      filled_r <= '0;
      ref_r    <= '0;
      mod_r    <= '0;
      flags_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      cmp_v_r  <= cmp_v_nxt;
      wp_v_r   <= wp_v_nxt;
      filled_r <= filled_nxt;
      ref_r    <= ref_nxt;
      mod_r    <= mod_nxt;
      flags_r  <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r    <= page_nxt;
    wr_r      <= wr_nxt;
    idx_r     <= idx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    best_r    <= best_nxt;
    slot_r    <= slot_nxt;
    vpage_r   <= vpage_nxt;
    vdirty_r  <= vdirty_nxt;
    sh_idx_r  <= sh_idx_nxt;
    wp_idx_r  <= wp_idx_nxt;
  end

  assign ready     = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res_flags = flags_r;
  assign res_page  = vpage_r;

  a_filled_max: assert property (@(posedge clk) disable iff (!rst_n)
    filled_r <= CNT_W'(FRAMES))
    else $error("fill count above frame count");

  a_hit_xor_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> !(flags_r.hit && flags_r.fault))
    else $error("hit and fault in one result");

  a_victim_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && flags_r.victim_valid) |-> flags_r.fault)
    else $error("victim without fault");

  a_refresh_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && start && op == OP_REFRESH) |=> (ref_r == '0))
    else $error("refresh left a reference bit set");

  a_front_ref: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FRONT) |=> ref_r[0])
    else $error("new page not marked referenced");

endmodule

// File: hdl/enhanced_second_chance_replacer.sv
// ----------------------------------------------------------------------------
// enhanced_second_chance_replacer
// page frame replacer with reference/modify classes and newest-first order
// ----------------------------------------------------------------------------
// refresh item: clears every reference bit and goes straight to the result
// access item: a scan of the filled frames; a miss adds a list shift and a
// front write before the result is ready
// one item at a time, set by the single frame memory port and compare unit
// reset clears fill count, reference and modify bits and the result slot;
// no clearing pass, page entries hold nothing until written
module enhanced_second_chance_replacer #(
  parameter int FRAMES    = esc_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = esc_pkg::PAGE_BITS_DEF,
  localparam int IN_W     = ((PAGE_BITS + 1 + 7) / 8) * 8,
  localparam int OUT_W    = ((PAGE_BITS + 4 + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [IN_W-1:0]           in_tdata,   // page_number, is_write
  input  logic                      in_tuser,   // operation
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [OUT_W-1:0]          out_tdata,  // hit, fault, victim_valid,
                                                // victim_page, victim_dirty
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [esc_pkg::CFG_W-1:0] cfg_data    // frames_in_use
);
  import esc_pkg::*;

  logic [CFG_W-1:0]     cfg_r;
  logic                 out_valid_r;
  esc_flags_t           out_flags_r;
  logic [PAGE_BITS-1:0] out_page_r;

  logic                 eng_ready;
  logic                 eng_valid;
  esc_flags_t           eng_flags;
  logic [PAGE_BITS-1:0] eng_page;
  logic                 take;

  assign in_tready = eng_ready;
  assign cfg_ready = 1'b1;
  assign take      = !out_valid_r || out_tready;

  esc_engine #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_tvalid && eng_ready),
    .op        (in_tuser),
    .page      (in_tdata[PAGE_BITS-1:0]),
    .wr        (in_tdata[PAGE_BITS]),
    .cfg_lim   (cfg_r),
    .res_take  (take),
    .ready     (eng_ready),
    .res_valid (eng_valid),
    .res_flags (eng_flags),
    .res_page  (eng_page)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= CFG_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cfg_r <= cfg_data;
      end
      if (eng_valid && take) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (eng_valid && take) begin
      out_flags_r <= eng_flags;
      out_page_r  <= eng_page;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_flags_r.victim_dirty, out_page_r,
                              out_flags_r.victim_valid, out_flags_r.fault,
                              out_flags_r.hit});

endmodule

// File: verif/enhanced_second_chance_replacer_tb.sv
// ----------------------------------------------------------------------------
// enhanced_second_chance_replacer_tb
// self-checking bench for the page replacer: a short table of directed
// accesses and refresh ticks, then random phases at several frame limits
// (zero, one, full, saturating, lowered below the fill level); every result
// is compared field by field with a table row's result or a model of the frame list
// ----------------------------------------------------------------------------
module enhanced_second_chance_replacer_tb;
  import esc_pkg::*;

  localparam int FR       = FRAMES_DEF;
  localparam int PG_W     = PAGE_BITS_DEF;
  localparam int IN_W     = ((PG_W + 1 + 7) / 8) * 8;
  localparam int OUT_W    = ((PG_W + 4 + 7) / 8) * 8;
  localparam int DRAIN    = 2 * FR + 8;
  localparam int HOLD_CYC = 300;
  localparam int N_DIR    = 20;
  localparam int N_PH     = 8;
  localparam int PH_ITEMS = 200;
  localparam int POOL_MAX = 24;

  typedef struct packed {
    logic            hit;
    logic            fault;
    logic            vvalid;
    logic [PG_W-1:0] vpage;
    logic            vdirty;
  } page_res_t;

  typedef struct {
    logic            op;
    logic [PG_W-1:0] page;
    logic            wr;
    bit              typed;
    page_res_t       res;
  } dir_row_t;

  localparam page_res_t R_NONE  = '0;
  localparam page_res_t R_HIT   = '{1'b1, 1'b0, 1'b0, '0, 1'b0};
  localparam page_res_t R_FAULT = '{1'b0, 1'b1, 1'b0, '0, 1'b0};

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             in_tuser;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data;

  // model of the frame list, slot 0 is the newest
  logic [PG_W-1:0]  frame_pg [FR];
  logic             ref_bit  [FR];
  logic             mod_bit  [FR];
  int               fill_cnt;
  logic [CFG_W-1:0] frames_lim;

  page_res_t        exp_q [$];
  int               errors;
  bit               hold_req;
  int               n_items, n_hit, n_fault, n_evict, n_dirty, n_tick;

  dir_row_t dir_tab [N_DIR] = '{
    '{OP_REFRESH, 20'hFFFFF, 1'b1, 1'b1, R_NONE},
    '{OP_ACCESS,  20'h00000, 1'b0, 1'b1, R_FAULT},
    '{OP_ACCESS,  20'hFFFFF, 1'b1, 1'b1, R_FAULT},
    '{OP_ACCESS,  20'h00000, 1'b0, 1'b1, R_HIT},
    '{OP_ACCESS,  20'hFFFFF, 1'b0, 1'b1, R_HIT},
    '{OP_ACCESS,  20'h12345, 1'b0, 1'b0, R_NONE},
    '{OP_REFRESH, 20'h00000, 1'b0, 1'b1, R_NONE},
    '{OP_ACCESS,  20'h00001, 1'b1, 1'b0, R_NONE},
    '{OP_ACCESS,  20'hFFFFF, 1'b1, 1'b0, R_NONE},
    '{OP_ACCESS,  20'h55555, 1'b0, 1'b0, R_NONE},
    '{OP_ACCESS,  20'hAAAAA, 1'b1, 1'b0, R_NONE},
    '{OP_REFRESH, 20'h55555, 1'b1, 1'b1, R_NONE},
    '{OP_ACCESS,  20'h55555, 1'b1, 1'b0, R_NONE},
    '{OP_ACCESS,  20'h0F0F0, 1'b0, 1'b0, R_NONE},
    '{OP_ACCESS,  20'hAAAAA, 1'b0, 1'b0, R_NONE},
    '{OP_ACCESS,  20'hFFFFF, 1'b1, 1'b0, R_NONE},
    '{OP_REFRESH, 20'hAAAAA, 1'b0, 1'b1, R_NONE},
    '{OP_ACCESS,  20'h00000, 1'b1, 1'b0, R_NONE},
    '{OP_ACCESS,  20'hFFFFF, 1'b0, 1'b0, R_NONE},
    '{OP_ACCESS,  20'h00000, 1'b0, 1'b0, R_NONE}
  };

  int ph_cfg [N_PH] = '{16, 0, 5, 31, 1, 17, 3, 10};

  enhanced_second_chance_replacer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // page_number, is_write
    .in_tuser   (in_tuser),    // operation
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // hit, fault, victim_valid, victim_page, victim_dirty
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)     // frames_in_use
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic page_res_t replace_page(logic op, logic [PG_W-1:0] page, logic wr);
    page_res_t r;
    int        i;
    int        lim;
    int        slot;
    int        best;
    int        cls;
    r = '0;
    if (op == OP_REFRESH) begin
      for (i = 0; i < FR; i++) ref_bit[i] = 1'b0;
      return r;
    end
    for (i = 0; i < fill_cnt; i++) begin
      if (frame_pg[i] == page) begin
        ref_bit[i] = 1'b1;
        if (wr) mod_bit[i] = 1'b1;
        r.hit = 1'b1;
        return r;
      end
    end
    r.fault = 1'b1;
    lim = int'(frames_lim);
    if (lim < 1) lim = 1;
    if (lim > FR) lim = FR;
    if (fill_cnt < lim) begin
      slot = fill_cnt;
      fill_cnt++;
    end else begin
      slot = 0;
      best = 4;
      for (i = 0; i < fill_cnt; i++) begin
        cls = {ref_bit[i], mod_bit[i]};
        if (cls < best) begin
          best = cls;
          slot = i;
        end
      end
      r.vvalid = 1'b1;
      r.vpage  = frame_pg[slot];
      r.vdirty = mod_bit[slot];
    end
    for (i = slot; i > 0; i--) begin
      frame_pg[i] = frame_pg[i-1];
      ref_bit[i]  = ref_bit[i-1];
      mod_bit[i]  = mod_bit[i-1];
    end
    frame_pg[0] = page;
    ref_bit[0]  = 1'b1;
    mod_bit[0]  = wr;
    return r;
  endfunction

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_item(input logic op, input logic [PG_W-1:0] page, input logic wr,
                           input bit typed, input page_res_t typed_res);
    page_res_t r;
    int        gap;
    in_tuser  = op;
    in_tdata  = '0;
    in_tdata[PG_W-1:0] = page;
    in_tdata[PG_W]     = wr;
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = replace_page(op, page, wr);
    exp_q.push_back(typed ? typed_res : r);
    n_items++;
    if (op == OP_REFRESH) n_tick++;
    if (r.hit) n_hit++;
    if (r.fault) n_fault++;
    if (r.vvalid) n_evict++;
    if (r.vdirty) n_dirty++;
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    in_tvalid = 1'b0;
    while (exp_q.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic write_limit(input logic [CFG_W-1:0] val);
    cfg_data  = val;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    frames_lim = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin : chk_res
    page_res_t e;
    page_res_t a;
    if (rst_n && out_tvalid && out_tready) begin
      a.hit    = out_tdata[0];
      a.fault  = out_tdata[1];
      a.vvalid = out_tdata[2];
      a.vpage  = out_tdata[PG_W+2:3];
      a.vdirty = out_tdata[PG_W+3];
      if (exp_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_tdata);
        errors++;
      end else begin
        e = exp_q.pop_front();
        if (a.hit !== e.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, e.hit, a.hit);
          errors++;
        end
        if (a.fault !== e.fault) begin
          $display("%0t: fault expected %0b actual %0b", $time, e.fault, a.fault);
          errors++;
        end
        if (a.vvalid !== e.vvalid) begin
          $display("%0t: victim_valid expected %0b actual %0b", $time, e.vvalid, a.vvalid);
          errors++;
        end
        if (a.vpage !== e.vpage) begin
          $display("%0t: victim_page expected %h actual %h", $time, e.vpage, a.vpage);
          errors++;
        end
        if (a.vdirty !== e.vdirty) begin
          $display("%0t: victim_dirty expected %0b actual %0b", $time, e.vdirty, a.vdirty);
          errors++;
        end
      end
    end
  end

  // result sink with random stalls and one long hold-off on request
  initial begin : sink
    int k;
    int n;
    out_tready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        out_tready = 1'b0;
        n = HOLD_CYC;
        hold_req = 1'b0;
      end else begin
        k = $urandom_range(0, 99);
        if (k < 55) begin
          out_tready = 1'b1;
          n = $urandom_range(1, 24);
        end else if (k < 92) begin
          out_tready = 1'b0;
          n = $urandom_range(1, 3);
        end else begin
          out_tready = 1'b0;
          n = $urandom_range(8, 40);
        end
      end
      repeat (n) @(negedge clk);
    end
  end

  initial begin : timeout
    #8000000;
    $display("%0t: timeout, %0d results outstanding", $time, exp_q.size());
    $display("enhanced_second_chance_replacer_tb failed");
    $finish;
  end

  initial begin : stim
    logic [PG_W-1:0] pool [POOL_MAX];
    int              pool_n;
    int              eff;
    int              p;
    int              j;
    int              k;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = OP_ACCESS;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    hold_req   = 1'b0;
    errors     = 0;
    n_items    = 0;
    n_hit      = 0;
    n_fault    = 0;
    n_evict    = 0;
    n_dirty    = 0;
    n_tick     = 0;
    fill_cnt   = 0;
    frames_lim = CFG_RESET;
    for (j = 0; j < FR; j++) begin
      frame_pg[j] = '0;
      ref_bit[j]  = 1'b0;
      mod_bit[j]  = 1'b0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed table with two frames so evictions start early
    write_limit(CFG_W'(2));
    for (j = 0; j < N_DIR; j++)
      send_item(dir_tab[j].op, dir_tab[j].page, dir_tab[j].wr, dir_tab[j].typed,
                dir_tab[j].res);

    for (p = 0; p < N_PH; p++) begin
      wait_idle();
      write_limit(CFG_W'(ph_cfg[p]));
      eff = ph_cfg[p];
      if (eff < 1) eff = 1;
      if (eff > FR) eff = FR;
      pool_n = (eff + 4 > POOL_MAX) ? POOL_MAX : eff + 4;
      for (j = 0; j < pool_n; j++) pool[j] = PG_W'($urandom());
      for (j = 0; j < PH_ITEMS; j++) begin
        if (p == 0 && j == 100) hold_req = 1'b1;
        if (p == 2 && j == 100) begin
          in_tvalid = 1'b0;
          while (exp_q.size() != 0) @(negedge clk);
        end
        k = $urandom_range(0, 99);
        if (k < 8)
          send_item(OP_REFRESH, PG_W'($urandom()), 1'($urandom()), 1'b0, R_NONE);
        else if (k < 78)
          send_item(OP_ACCESS, pool[$urandom_range(0, pool_n - 1)], 1'($urandom()),
                    1'b0, R_NONE);
        else
          send_item(OP_ACCESS, PG_W'($urandom()), 1'($urandom()), 1'b0, R_NONE);
      end
    end

    in_tvalid = 1'b0;
    while (exp_q.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    $display("covered %0d items at %0d frame limits: %0d hits, %0d faults, %0d ticks",
             n_items, N_PH + 1, n_hit, n_fault, n_tick);
    $display("%0d evictions, %0d of them dirty, %0d mismatches", n_evict, n_dirty, errors);
    if (errors == 0)
      $display("enhanced_second_chance_replacer_tb passed");
    else
      $display("enhanced_second_chance_replacer_tb failed");
    $finish;
  end

endmodule

// File: enhanced_second_chance_replacer.f
hdl/esc_pkg.sv
hdl/esc_engine.sv
hdl/enhanced_second_chance_replacer.sv
verif/enhanced_second_chance_replacer_tb.sv
